/* src/iste_pkg.sv */
// Shared types, character codes and parser modes for the IMAP string token extractor.
package iste_pkg;

	localparam int LITERAL_COUNT_BITS = 32;
	localparam int MAX_RESULTS        = 4;
	localparam int RESULT_CNT_BITS    = $clog2(MAX_RESULTS + 1);
	localparam int IDX_BITS           = $clog2(MAX_RESULTS);

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_N      = 8'h4E;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_L      = 8'h4C;

	typedef enum logic [2:0] {
		MODE_IDLE        = 3'd0,
		MODE_ATOM        = 3'd1,
		MODE_QUOTED      = 3'd2,
		MODE_COUNT       = 3'd3,
		MODE_AFTER_BRACE = 3'd4,
		MODE_AFTER_CR    = 3'd5,
		MODE_DATA        = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		KIND_ATOM    = 2'd0,
		KIND_QUOTED  = 2'd1,
		KIND_LITERAL = 2'd2,
		KIND_NIL     = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       string_end;
		kind_t      kind;
	} result_t;

	// All results caused by one input word, filled from entry 0 upward.
	typedef struct packed {
		result_t [MAX_RESULTS-1:0]  res;
		logic [RESULT_CNT_BITS-1:0] count;
	} burst_t;

endpackage

/* src/iste_parse.sv */
// Parser state and the single-pass step that turns one byte into a burst of results.
module iste_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  logic [7:0]          byte_in,
	output iste_pkg::burst_t    burst
);

	localparam int CB = iste_pkg::LITERAL_COUNT_BITS;
	localparam logic [7:0] NIL_LETTERS [3] = '{iste_pkg::CH_N, iste_pkg::CH_I, iste_pkg::CH_L};

	iste_pkg::mode_t mode_q, mode_d;
	logic            esc_q, esc_d;
	logic [1:0]      held_q, held_d;
	logic [CB-1:0]   rem_q, rem_d;

	logic [CB+3:0]   count_x10;
	logic [CB-1:0]   count_sat;
	logic [CB-1:0]   rem_dec;

	function automatic iste_pkg::burst_t put(iste_pkg::burst_t b, logic [7:0] d, logic v,
			logic e, iste_pkg::kind_t k);
		iste_pkg::burst_t r;
		r = b;
		if (b.count < iste_pkg::RESULT_CNT_BITS'(iste_pkg::MAX_RESULTS)) begin
			r.res[b.count[iste_pkg::IDX_BITS-1:0]] = '{data: d, valid: v, string_end: e, kind: k};
			r.count = b.count + 1'b1;
		end
		return r;
	endfunction

	function automatic logic atom_stop(logic [7:0] b);
		return b inside {iste_pkg::CH_SPACE, iste_pkg::CH_LPAREN, iste_pkg::CH_RPAREN,
			iste_pkg::CH_LBRACK, iste_pkg::CH_RBRACK, iste_pkg::CH_CR, iste_pkg::CH_LF,
			iste_pkg::CH_QUOTE};
	endfunction

	// Saturating count * 10 + digit
	assign count_x10 = {1'b0, rem_q, 3'b000} + {3'b000, rem_q, 1'b0}
		+ {(CB)'(0), (byte_in[3:0] - iste_pkg::CH_ZERO[3:0])};
	assign count_sat = (count_x10[CB+3:CB] != 4'd0) ? {CB{1'b1}} : count_x10[CB-1:0];
	assign rem_dec   = rem_q - {{(CB-1){1'b0}}, (rem_q != '0)};

	always_comb begin
		logic do_idle;
		logic do_data;
		logic skip;
		do_idle = 1'b0;
		do_data = 1'b0;
		skip    = 1'b0;
		burst   = '0;
		mode_d  = mode_q;
		esc_d   = esc_q;
		held_d  = held_q;
		rem_d   = rem_q;
		unique case (mode_q) inside
			iste_pkg::MODE_ATOM: begin
				if (atom_stop(byte_in)) begin
					if (held_q == 2'd3) begin
						burst = put(burst, 8'h00, 1'b0, 1'b1, iste_pkg::KIND_NIL);
					end else begin
						for (int k = 0; k < 3; k++) begin
							if (2'(k) < held_q)
								burst = put(burst, NIL_LETTERS[k], 1'b1, 1'b0, iste_pkg::KIND_ATOM);
						end
						if (esc_q)
							burst = put(burst, iste_pkg::CH_BSLASH, 1'b1, 1'b0, iste_pkg::KIND_ATOM);
						burst = put(burst, 8'h00, 1'b0, 1'b1, iste_pkg::KIND_ATOM);
					end
					held_d = 2'd0;
					esc_d  = 1'b0;
					mode_d = iste_pkg::MODE_IDLE;
				end else begin
					if (esc_q) begin
						esc_d = 1'b0;
						burst = put(burst, iste_pkg::CH_BSLASH, 1'b1, 1'b0, iste_pkg::KIND_ATOM);
						skip  = (byte_in == iste_pkg::CH_BSLASH);
					end
					if (!skip) begin
						if (held_q == 2'd1 && byte_in == iste_pkg::CH_I) begin
							held_d = 2'd2;
						end else if (held_q == 2'd2 && byte_in == iste_pkg::CH_L) begin
							held_d = 2'd3;
						end else begin
							for (int k = 0; k < 3; k++) begin
								if (2'(k) < held_q)
									burst = put(burst, NIL_LETTERS[k], 1'b1, 1'b0,
										iste_pkg::KIND_ATOM);
							end
							held_d = 2'd0;
							if (byte_in == iste_pkg::CH_BSLASH)
								esc_d = 1'b1;
							else
								burst = put(burst, byte_in, 1'b1, 1'b0, iste_pkg::KIND_ATOM);
						end
					end
				end
			end
			iste_pkg::MODE_QUOTED: begin
				if (esc_q) begin
					esc_d = 1'b0;
					if (byte_in != iste_pkg::CH_QUOTE && byte_in != iste_pkg::CH_BSLASH)
						burst = put(burst, iste_pkg::CH_BSLASH, 1'b1, 1'b0, iste_pkg::KIND_QUOTED);
					burst = put(burst, byte_in, 1'b1, 1'b0, iste_pkg::KIND_QUOTED);
				end else if (byte_in == iste_pkg::CH_BSLASH) begin
					esc_d = 1'b1;
				end else if (byte_in == iste_pkg::CH_QUOTE) begin
					burst  = put(burst, 8'h00, 1'b0, 1'b1, iste_pkg::KIND_QUOTED);
					mode_d = iste_pkg::MODE_IDLE;
				end else begin
					burst = put(burst, byte_in, 1'b1, 1'b0, iste_pkg::KIND_QUOTED);
				end
			end
			iste_pkg::MODE_COUNT: begin
				if (byte_in == iste_pkg::CH_RBRACE) begin
					esc_d  = 1'b0;
					mode_d = iste_pkg::MODE_AFTER_BRACE;
				end else if (byte_in >= iste_pkg::CH_ZERO && byte_in <= iste_pkg::CH_NINE
						&& !esc_q) begin
					rem_d = count_sat;
				end else begin
					// any bad character zeroes the count for good
					esc_d = 1'b1;
					rem_d = '0;
				end
			end
			iste_pkg::MODE_AFTER_BRACE, iste_pkg::MODE_AFTER_CR: begin
				if (mode_q == iste_pkg::MODE_AFTER_BRACE && byte_in == iste_pkg::CH_CR) begin
					mode_d = iste_pkg::MODE_AFTER_CR;
				end else if (byte_in == iste_pkg::CH_LF) begin
					if (rem_q == '0) begin
						burst  = put(burst, 8'h00, 1'b0, 1'b1, iste_pkg::KIND_LITERAL);
						mode_d = iste_pkg::MODE_IDLE;
					end else begin
						mode_d = iste_pkg::MODE_DATA;
					end
				end else if (rem_q == '0) begin
					// empty literal: close it, then reparse this byte from idle
					burst   = put(burst, 8'h00, 1'b0, 1'b1, iste_pkg::KIND_LITERAL);
					do_idle = 1'b1;
				end else begin
					do_data = 1'b1;
				end
			end
			iste_pkg::MODE_DATA: begin
				do_data = 1'b1;
			end
			default: begin
				do_idle = 1'b1;
			end
		endcase

		if (do_data) begin
			rem_d = rem_dec;
			if (rem_dec == '0) begin
				burst  = put(burst, byte_in, 1'b1, 1'b1, iste_pkg::KIND_LITERAL);
				mode_d = iste_pkg::MODE_IDLE;
			end else begin
				burst  = put(burst, byte_in, 1'b1, 1'b0, iste_pkg::KIND_LITERAL);
				mode_d = iste_pkg::MODE_DATA;
			end
		end

		if (do_idle) begin
			esc_d  = 1'b0;
			held_d = 2'd0;
			mode_d = iste_pkg::MODE_IDLE;
			if (byte_in == iste_pkg::CH_SPACE) begin
				mode_d = iste_pkg::MODE_IDLE;
			end else if (byte_in == iste_pkg::CH_LBRACE) begin
				mode_d = iste_pkg::MODE_COUNT;
				rem_d  = '0;
			end else if (byte_in == iste_pkg::CH_QUOTE) begin
				mode_d = iste_pkg::MODE_QUOTED;
			end else if (atom_stop(byte_in)) begin
				burst = put(burst, 8'h00, 1'b0, 1'b1, iste_pkg::KIND_ATOM);
			end else begin
				mode_d = iste_pkg::MODE_ATOM;
				if (byte_in == iste_pkg::CH_N)
					held_d = 2'd1;
				else if (byte_in == iste_pkg::CH_BSLASH)
					esc_d = 1'b1;
				else
					burst = put(burst, byte_in, 1'b1, 1'b0, iste_pkg::KIND_ATOM);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= iste_pkg::MODE_IDLE;
			esc_q  <= 1'b0;
			held_q <= 2'd0;
			rem_q  <= '0;
		end else if (step_en) begin
			mode_q <= mode_d;
			esc_q  <= esc_d;
			held_q <= held_d;
			rem_q  <= rem_d;
		end
	end

	a_held_only_in_atom: assert property (@(posedge clk) disable iff (!arst_n)
		held_q != 2'd0 |-> mode_q == iste_pkg::MODE_ATOM)
		else $error("NIL prefix held outside an atom");

	a_data_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == iste_pkg::MODE_DATA |-> rem_q != '0)
		else $error("literal data mode with zero bytes remaining");

endmodule

/* src/iste_emit.sv */
// Result register: holds one burst and hands its results out one word at a time.
module iste_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_en,
	input  iste_pkg::burst_t    burst,
	output logic                load_ok,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,
	output logic [3:0]          m_tuser,
	output logic                m_tlast
);

	iste_pkg::burst_t                buf_q;
	logic [iste_pkg::IDX_BITS-1:0]   idx_q;
	logic                            vld_q;
	iste_pkg::result_t               cur;

	assign cur      = buf_q.res[idx_q];
	assign m_tlast  = ({1'b0, idx_q} + 1'b1) == buf_q.count;
	assign m_tvalid = vld_q;
	// fields from bit 0: out_byte[7:0]
	assign m_tdata  = cur.data;
	// fields from bit 0: byte_valid, string_end, string_kind[1:0]
	assign m_tuser  = {cur.kind, cur.string_end, cur.valid};
	assign load_ok  = !vld_q || (m_tready && m_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else if (load_ok) begin
			vld_q <= load_en && (burst.count != '0);
			idx_q <= '0;
		end else if (m_tready) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok && load_en)
			buf_q <= burst;
	end

	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> buf_q.count != '0)
		else $error("result register valid with an empty burst");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> {1'b0, idx_q} < buf_q.count)
		else $error("result index past end of burst");

endmodule

/* src/imap_string_token_extractor.sv */
// Top level of the IMAP string token extractor: input register, parser and result register.
//
// channel | dir | handshake          | payload
// --------+-----+--------------------+-----------------------------------------------------
// s_      | in  | s_tvalid, s_tready | s_tdata[7:0] in_byte
// m_      | out | m_tvalid, m_tready | m_tdata[7:0] out_byte; m_tuser byte_valid,
//         |     |                    | string_end, string_kind; m_tlast = last_of_run
//
// One byte can be taken every cycle while the result register can take its burst. It is
// registered in the input register, parsed in a single pass, and its results (zero to
// four) land together in the result register. A byte with more than one result keeps the
// next byte in the input register until its last result word is taken, set by the single
// output port of the result register; bytes with no result (spaces, count digits) pass
// freely. arst_n clears the parser to idle and empties both registers. A stall on m_tready
// holds the current word and, once the input register is full, drops s_tready.
module imap_string_token_extractor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte[7:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte[7:0]
	output logic [3:0]  m_tuser,   // byte_valid, string_end, string_kind[1:0]
	output logic        m_tlast
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             load_ok;
	logic             advance;
	iste_pkg::burst_t burst;

	// parse the held byte only when the result register can take its burst
	assign advance  = valid_s1 && load_ok;
	assign s_tready = !valid_s1 || load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			byte_s1 <= s_tdata;
	end

	iste_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.byte_in (byte_s1),
		.burst   (burst)
	);

	iste_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load_en  (advance),
		.burst    (burst),
		.load_ok  (load_ok),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the IMAP string token extractor.
`timescale 1ns / 1ps

module tb;

	// Give up on a hung run: a few hundred bytes at up to four words each, even under
	// heavy output stalls and the long hold-off, stay far below this.
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [iste_pkg::LITERAL_COUNT_BITS-1:0] COUNT_MAX = '1;

	// One expected result word, in the order the parser emits them.
	typedef struct packed {
		logic [7:0]      data;
		logic            valid;
		logic            str_end;
		iste_pkg::kind_t kind;
		logic            last;
	} word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;   // out_byte[7:0]
	logic [3:0]  m_tuser;   // byte_valid, string_end, string_kind[1:0]
	logic        m_tlast;

	// Parser state mirrored on the testbench side.
	iste_pkg::mode_t                         pmode = iste_pkg::MODE_IDLE;
	logic                                    esc_held = 1'b0;
	logic [1:0]                              nil_held = 2'd0;
	logic [iste_pkg::LITERAL_COUNT_BITS-1:0] lit_left = '0;

	word_t burst[$];           // words caused by the byte being parsed
	word_t pending_words[$];   // words still owed by the block, oldest first

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_len = 0;          // requested output hold-off, picked up by the receiver
	int hold_left = 0;
	int bytes_sent = 0;
	int words_seen = 0;
	int errors = 0;
	int cycle_count = 0;

	imap_string_token_extractor uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------

	function automatic logic is_stop(logic [7:0] b);
		return b == iste_pkg::CH_SPACE || b == iste_pkg::CH_LPAREN ||
			b == iste_pkg::CH_RPAREN || b == iste_pkg::CH_LBRACK ||
			b == iste_pkg::CH_RBRACK || b == iste_pkg::CH_CR || b == iste_pkg::CH_LF ||
			b == iste_pkg::CH_QUOTE;
	endfunction

	function automatic void emit(logic [7:0] d, logic v, logic e, iste_pkg::kind_t k);
		word_t w;
		w.data    = d;
		w.valid   = v;
		w.str_end = e;
		w.kind    = k;
		w.last    = 1'b0;
		if (burst.size() < iste_pkg::MAX_RESULTS)
			burst.push_back(w);
	endfunction

	// Release the N, I, L held back at the start of an atom.
	function automatic void flush_nil();
		for (int k = 0; k < nil_held; k++) begin
			emit(k == 0 ? iste_pkg::CH_N : (k == 1 ? iste_pkg::CH_I : iste_pkg::CH_L),
				1'b1, 1'b0, iste_pkg::KIND_ATOM);
		end
		nil_held = 2'd0;
	endfunction

	function automatic void atom_byte(logic [7:0] b);
		if (esc_held) begin
			esc_held = 1'b0;
			emit(iste_pkg::CH_BSLASH, 1'b1, 1'b0, iste_pkg::KIND_ATOM);
			if (b == iste_pkg::CH_BSLASH)
				return;
		end
		if (nil_held == 2'd1 && b == iste_pkg::CH_I) begin
			nil_held = 2'd2;
			return;
		end
		if (nil_held == 2'd2 && b == iste_pkg::CH_L) begin
			nil_held = 2'd3;
			return;
		end
		if (nil_held != 2'd0)
			flush_nil();
		if (b == iste_pkg::CH_BSLASH)
			esc_held = 1'b1;
		else
			emit(b, 1'b1, 1'b0, iste_pkg::KIND_ATOM);
	endfunction

	function automatic void atom_close();
		if (nil_held == 2'd3) begin
			emit(8'h00, 1'b0, 1'b1, iste_pkg::KIND_NIL);
		end else begin
			flush_nil();
			if (esc_held)
				emit(iste_pkg::CH_BSLASH, 1'b1, 1'b0, iste_pkg::KIND_ATOM);
			emit(8'h00, 1'b0, 1'b1, iste_pkg::KIND_ATOM);
		end
		nil_held = 2'd0;
		esc_held = 1'b0;
		pmode    = iste_pkg::MODE_IDLE;
	endfunction

	function automatic void idle_byte(logic [7:0] b);
		esc_held = 1'b0;
		nil_held = 2'd0;
		if (b == iste_pkg::CH_SPACE)
			return;
		if (b == iste_pkg::CH_LBRACE) begin
			pmode    = iste_pkg::MODE_COUNT;
			lit_left = '0;
			return;
		end
		if (b == iste_pkg::CH_QUOTE) begin
			pmode = iste_pkg::MODE_QUOTED;
			return;
		end
		// A delimiter where an argument should start is an empty atom.
		if (is_stop(b)) begin
			emit(8'h00, 1'b0, 1'b1, iste_pkg::KIND_ATOM);
			return;
		end
		pmode = iste_pkg::MODE_ATOM;
		if (b == iste_pkg::CH_N)
			nil_held = 2'd1;
		else
			atom_byte(b);
	endfunction

	function automatic void data_byte(logic [7:0] b);
		if (lit_left != 0)
			lit_left--;
		if (lit_left == 0) begin
			emit(b, 1'b1, 1'b1, iste_pkg::KIND_LITERAL);
			pmode = iste_pkg::MODE_IDLE;
		end else begin
			emit(b, 1'b1, 1'b0, iste_pkg::KIND_LITERAL);
		end
	endfunction

	function automatic void literal_begin();
		if (lit_left == 0) begin
			emit(8'h00, 1'b0, 1'b1, iste_pkg::KIND_LITERAL);
			pmode = iste_pkg::MODE_IDLE;
		end else begin
			pmode = iste_pkg::MODE_DATA;
		end
	endfunction

	// A byte after the brace that is not the optional CR or LF: an empty literal hands
	// it to the next argument, otherwise it is the first content byte.
	function automatic void literal_other(logic [7:0] b);
		if (lit_left == 0) begin
			emit(8'h00, 1'b0, 1'b1, iste_pkg::KIND_LITERAL);
			pmode = iste_pkg::MODE_IDLE;
			idle_byte(b);
		end else begin
			pmode = iste_pkg::MODE_DATA;
			data_byte(b);
		end
	endfunction

	// Advance the model by one accepted input word and queue the words it owes.
	function automatic void parse_byte(logic [7:0] b);
		logic [iste_pkg::LITERAL_COUNT_BITS-1:0] d;
		burst.delete();
		case (pmode)
			iste_pkg::MODE_ATOM: begin
				if (is_stop(b))
					atom_close();
				else
					atom_byte(b);
			end
			iste_pkg::MODE_QUOTED: begin
				if (esc_held) begin
					esc_held = 1'b0;
					if (b != iste_pkg::CH_QUOTE && b != iste_pkg::CH_BSLASH)
						emit(iste_pkg::CH_BSLASH, 1'b1, 1'b0, iste_pkg::KIND_QUOTED);
					emit(b, 1'b1, 1'b0, iste_pkg::KIND_QUOTED);
				end else if (b == iste_pkg::CH_BSLASH) begin
					esc_held = 1'b1;
				end else if (b == iste_pkg::CH_QUOTE) begin
					emit(8'h00, 1'b0, 1'b1, iste_pkg::KIND_QUOTED);
					pmode = iste_pkg::MODE_IDLE;
				end else begin
					emit(b, 1'b1, 1'b0, iste_pkg::KIND_QUOTED);
				end
			end
			iste_pkg::MODE_COUNT: begin
				// esc_held marks a bad count here; it pins the count at zero.
				if (b == iste_pkg::CH_RBRACE) begin
					esc_held = 1'b0;
					pmode    = iste_pkg::MODE_AFTER_BRACE;
				end else if (b >= iste_pkg::CH_ZERO && b <= iste_pkg::CH_NINE && !esc_held) begin
					d = iste_pkg::LITERAL_COUNT_BITS'(b - iste_pkg::CH_ZERO);
					if (lit_left > (COUNT_MAX - d) / 10)
						lit_left = COUNT_MAX;
					else
						lit_left = lit_left * 10 + d;
				end else begin
					esc_held = 1'b1;
					lit_left = '0;
				end
			end
			iste_pkg::MODE_AFTER_BRACE: begin
				if (b == iste_pkg::CH_CR)
					pmode = iste_pkg::MODE_AFTER_CR;
				else if (b == iste_pkg::CH_LF)
					literal_begin();
				else
					literal_other(b);
			end
			iste_pkg::MODE_AFTER_CR: begin
				if (b == iste_pkg::CH_LF)
					literal_begin();
				else
					literal_other(b);
			end
			iste_pkg::MODE_DATA: data_byte(b);
			default: begin
				pmode = iste_pkg::MODE_IDLE;
				idle_byte(b);
			end
		endcase
		if (burst.size() > 0)
			burst[burst.size() - 1].last = 1'b1;
		foreach (burst[i])
			pending_words.push_back(burst[i]);
	endfunction

	// ------------------------------------------------------------------
	// Sender, receiver and checker
	// ------------------------------------------------------------------

	// Offer one byte, with a random gap first; valid stays high after the accept so
	// that back-to-back bytes need no second assignment in the same step.
	task automatic push_byte(input logic [7:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
		parse_byte(b);
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	// Drop valid in the step of the last accept, then wait for every owed word; the loop
	// waits on the clock before it tests, so the next offer lands in a later step.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_words.size() != 0);
	endtask

	// Ready toggles at random; a requested hold-off overrides it for a counted stretch.
	always @(posedge clk) begin
		if (hold_len != 0) begin
			hold_left = hold_len;
			hold_len  = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare every accepted result word with the oldest expectation.
	always @(posedge clk) begin : check_words
		word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			words_seen++;
			if (pending_words.size() == 0) begin
				errors++;
				$error("unexpected result word: out_byte %0h, m_tuser %0h, m_tlast %0b",
					m_tdata, m_tuser, m_tlast);
			end else begin
				want = pending_words.pop_front();
				if (m_tdata !== want.data) begin
					errors++;
					$error("out_byte mismatch: expected %0h, got %0h", want.data, m_tdata);
				end
				if (m_tuser[0] !== want.valid) begin
					errors++;
					$error("byte_valid mismatch: expected %0b, got %0b", want.valid,
						m_tuser[0]);
				end
				if (m_tuser[1] !== want.str_end) begin
					errors++;
					$error("string_end mismatch: expected %0b, got %0b", want.str_end,
						m_tuser[1]);
				end
				if (m_tuser[3:2] !== want.kind) begin
					errors++;
					$error("string_kind mismatch: expected %0d, got %0d", want.kind,
						m_tuser[3:2]);
				end
				if (m_tlast !== want.last) begin
					errors++;
					$error("last_of_run mismatch: expected %0b, got %0b", want.last, m_tlast);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	function automatic logic [7:0] pick_delim();
		case ($urandom_range(5))
			0: return iste_pkg::CH_LPAREN;
			1: return iste_pkg::CH_RPAREN;
			2: return iste_pkg::CH_LBRACK;
			3: return iste_pkg::CH_RBRACK;
			4: return iste_pkg::CH_CR;
			default: return iste_pkg::CH_LF;
		endcase
	endfunction

	// One well-formed argument with random content, or a little noise, then a separator.
	task automatic send_random_arg();
		int pick;
		int len;
		int n;
		logic [7:0] b;
		pick = $urandom_range(99);
		if (pick < 30) begin
			len = $urandom_range(1, 6);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(7) == 0) begin
					b = iste_pkg::CH_BSLASH;
				end else begin
					b = $urandom_range(255);
					while (is_stop(b) ||
							(i == 0 && (b == iste_pkg::CH_LBRACE || b == iste_pkg::CH_N)))
						b = $urandom_range(255);
				end
				push_byte(b);
			end
		end else if (pick < 40) begin
			case ($urandom_range(4))
				0: push_str("NIL");
				1: push_str("NI");
				2: push_str("N");
				3: push_str("NILx");
				default: push_str("NIL\\");
			endcase
		end else if (pick < 65) begin
			push_byte(iste_pkg::CH_QUOTE);
			len = $urandom_range(0, 6);
			for (int i = 0; i < len; i++) begin
				b = $urandom_range(255);
				// Escape quote and backslash, and now and then any other byte.
				if (b == iste_pkg::CH_QUOTE || b == iste_pkg::CH_BSLASH ||
						$urandom_range(9) == 0)
					push_byte(iste_pkg::CH_BSLASH);
				push_byte(b);
			end
			push_byte(iste_pkg::CH_QUOTE);
		end else if (pick < 90) begin
			n = $urandom_range(0, 8);
			push_byte(iste_pkg::CH_LBRACE);
			if ($urandom_range(9) == 0) begin
				push_str("7x");
				n = 0;
			end else begin
				push_str($sformatf("%0d", n));
			end
			push_byte(iste_pkg::CH_RBRACE);
			case ($urandom_range(3))
				0: push_str("\r\n");
				1: push_byte(iste_pkg::CH_LF);
				2: push_byte(iste_pkg::CH_CR);
				default: ;
			endcase
			for (int i = 0; i < n; i++)
				push_byte($urandom_range(255));
		end else begin
			len = $urandom_range(1, 3);
			for (int i = 0; i < len; i++)
				push_byte($urandom_range(255));
		end
		if ($urandom_range(9) == 0)
			push_byte(pick_delim());
		else
			push_byte(iste_pkg::CH_SPACE);
	endtask

	// Each string form, the byte extremes and the escape, NIL and empty-literal cases.
	task automatic test_directed();
		send_idle_pct = 30;
		recv_idle_pct = 68;
		// escaped quote, escaped backslash, backslash kept with an ordinary byte
		push_str("\"\\\"\\\\\\q\"");
		// NIL closed by a parenthesis, then a bracket where an argument should start
		push_str("NIL)]");
		// held N, I released by the next byte; extremes; backslash held at the atom end
		push_str("NI");
		push_byte(8'h00);
		push_byte(8'hFF);
		push_str("\\\n");
		// bad count gives an empty literal closed at the LF
		push_str("{1x}\r\n");
		// empty literal with no CR/LF: the Q opens the next atom
		push_str("{0}Q ");
		drain();
	endtask

	task automatic test_random(input int send_pct, input int recv_pct, input int n_bytes);
		int stop_at;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at)
			send_random_arg();
		drain();
	endtask

	// Hold the output for a long stretch while the sender keeps offering words, so the
	// block fills up and drops s_tready.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_len      = 300;
		repeat (12) push_str("ab ");
		drain();
	endtask

	// A count too big for the counter saturates; the literal then swallows the rest of
	// the stream, so this runs last.
	task automatic test_count_saturation();
		send_idle_pct = 0;
		recv_idle_pct = 30;
		push_str("{99999999999}\r\n");
		repeat (8) push_byte($urandom_range(255));
		drain();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(30, 68, 45);
		test_random(68, 30, 45);
		test_random(0, 0, 45);
		test_backpressure();
		test_count_saturation();
		// Let any stray word surface before the verdict.
		repeat (10) @(posedge clk);
		$display("Sent %0d input words and checked %0d result words.", bytes_sent, words_seen);
		$display("Covered all string forms, three idle mixes, a long output stall, count overflow.");
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
